@@ hdl/grr_pkg.sv @@
// ----------------------------------------------------------------------------
// grr_pkg
// shared constants, codes and types of the graph reachability engine
// ----------------------------------------------------------------------------
package grr_pkg;

  localparam int MAX_NODES_DEF = 64;

  localparam int NODE_IN_W = 6;
  localparam int OP_W      = 2;
  localparam int NCNT_W    = 7;
  localparam int MDEG_W    = 6;
  localparam int DEG_W     = 7;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 7'd64;
  localparam logic [MDEG_W-1:0] MAX_DEG_RST    = 6'd2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_REACH = 2'd2,
    OP_CYCLE = 2'd3
  } op_t;

  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_MAX_DEG    = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

endpackage

@@ hdl/grr_store.sv @@
// ----------------------------------------------------------------------------
// grr_store
// adjacency row memory and out-degree memory with per-row valid bits
// ----------------------------------------------------------------------------
module grr_store #(
  parameter int MAX_NODES = grr_pkg::MAX_NODES_DEF,
  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  grr_pkg::mem_ctl_t          ctl,
  input  logic [NODE_W-1:0]          rd_addr,
  input  logic [NODE_W-1:0]          wr_addr,
  input  logic [MAX_NODES-1:0]       wr_row,
  input  logic [grr_pkg::DEG_W-1:0]  wr_deg,
  output logic [MAX_NODES-1:0]       rd_row,
  output logic [grr_pkg::DEG_W-1:0]  rd_deg
);

  logic [MAX_NODES-1:0]      adj_mem [MAX_NODES];
  logic [grr_pkg::DEG_W-1:0] deg_mem [MAX_NODES];
  logic [MAX_NODES-1:0]      vld_r, vld_nxt;
  logic                      rd_vld_r;
  logic [MAX_NODES-1:0]      rd_row_q;
  logic [grr_pkg::DEG_W-1:0] rd_deg_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      adj_mem[wr_addr] <= wr_row;
      deg_mem[wr_addr] <= wr_deg;
    end
    if (ctl.rd_en) begin
      rd_row_q <= adj_mem[rd_addr];
      rd_deg_q <= deg_mem[rd_addr];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (ctl.clr) begin
      vld_nxt = '0;
    end else if (ctl.wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (ctl.rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_row = rd_vld_r ? rd_row_q : '0;
  assign rd_deg = rd_vld_r ? rd_deg_q : '0;

endmodule

@@ hdl/grr_ctrl.sv @@
// ----------------------------------------------------------------------------
// grr_ctrl
// operation sequencer: clear, edge insert, reachability sweeps and cycle peeling
// ----------------------------------------------------------------------------
module grr_ctrl #(
  parameter int MAX_NODES = grr_pkg::MAX_NODES_DEF,
  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int CNT_W  = $clog2(MAX_NODES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [grr_pkg::OP_W-1:0]      op,
  input  logic [grr_pkg::NODE_IN_W-1:0] src,
  input  logic [grr_pkg::NODE_IN_W-1:0] dst,
  input  logic [CNT_W-1:0]              n,
  input  logic [grr_pkg::MDEG_W-1:0]    max_deg,
  output logic                          busy,
  output logic                          out_valid,
  output logic                          out_edge_added,
  output logic                          out_reachable,
  output logic                          out_has_cycle,
  output logic                          out_status,
  output grr_pkg::mem_ctl_t             ctl,
  output logic [NODE_W-1:0]             rd_addr,
  output logic [NODE_W-1:0]             wr_addr,
  output logic [MAX_NODES-1:0]          wr_row,
  output logic [grr_pkg::DEG_W-1:0]     wr_deg,
  input  logic [MAX_NODES-1:0]          rd_row,
  input  logic [grr_pkg::DEG_W-1:0]     rd_deg
);

  localparam int CW = (CNT_W > grr_pkg::NODE_IN_W) ? CNT_W : grr_pkg::NODE_IN_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ADD   = 3'b010,
    S_SWEEP = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  grr_pkg::op_t         op_r, op_nxt;
  logic [NODE_W-1:0]    s_r, s_nxt, d_r, d_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [NODE_W-1:0]    pidx_r, pidx_nxt;
  logic                 pend_r, pend_nxt;
  logic                 chg_r, chg_nxt;
  logic [MAX_NODES-1:0] vec_r, vec_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_edge_r, out_edge_nxt;
  logic                 out_reach_r, out_reach_nxt;
  logic                 out_cyc_r, out_cyc_nxt;
  logic                 out_stat_r, out_stat_nxt;

  logic [MAX_NODES-1:0] act;
  logic [MAX_NODES-1:0] vec_w, add_w;
  logic                 chg_w;
  logic [NODE_W-1:0]    s_idx, d_idx;
  logic                 oob;
  grr_pkg::op_t         op_in;

  assign op_in = grr_pkg::op_t'(op);
  assign s_idx = NODE_W'(src);
  assign d_idx = NODE_W'(dst);
  assign oob   = (CW'(src) >= CW'(n)) || (CW'(dst) >= CW'(n));

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      act[i] = (i < int'(n));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    s_nxt         = s_r;
    d_nxt         = d_r;
    idx_nxt       = idx_r;
    pidx_nxt      = pidx_r;
    pend_nxt      = pend_r;
    chg_nxt       = chg_r;
    vec_nxt       = vec_r;
    out_valid_nxt = 1'b0;
    out_edge_nxt  = 1'b0;
    out_reach_nxt = 1'b0;
    out_cyc_nxt   = 1'b0;
    out_stat_nxt  = 1'b0;
    ctl           = '0;
    rd_addr       = idx_r[NODE_W-1:0];
    wr_addr       = s_r;
    wr_row        = rd_row | (MAX_NODES'(1) << d_r);
    wr_deg        = rd_deg + grr_pkg::DEG_W'(1);
    vec_w         = vec_r;
    chg_w         = chg_r;
    add_w         = rd_row & act & ~vec_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = op_in;
          s_nxt    = s_idx;
          d_nxt    = d_idx;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          chg_nxt  = 1'b0;
          case (op_in)
            grr_pkg::OP_CLEAR: begin
              ctl.clr       = 1'b1;
              out_valid_nxt = 1'b1;
            end
            grr_pkg::OP_CYCLE: begin
              if (n == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                vec_nxt   = act;
                state_nxt = S_SWEEP;
              end
            end
            default: begin
              if (oob) begin
                out_valid_nxt = 1'b1;
                out_stat_nxt  = 1'b1;
              end else if (op_in == grr_pkg::OP_ADD) begin
                ctl.rd_en = 1'b1;
                rd_addr   = s_idx;
                state_nxt = S_ADD;
              end else if (s_idx == d_idx) begin
                out_valid_nxt = 1'b1;
                out_reach_nxt = 1'b1;
              end else begin
                vec_nxt   = MAX_NODES'(1) << s_idx;
                state_nxt = S_SWEEP;
              end
            end
          endcase
        end
      end
      S_ADD: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if ((s_r != d_r) && (rd_deg < grr_pkg::DEG_W'(max_deg))) begin
          out_edge_nxt = 1'b1;
          ctl.wr_en    = !rd_row[d_r];
        end
      end
      S_SWEEP: begin
        if (pend_r && vec_r[pidx_r]) begin
          if (op_r == grr_pkg::OP_REACH) begin
            vec_w = vec_r | add_w;
            if (|add_w) begin
              chg_w = 1'b1;
            end
          end else if (!(|(rd_row & vec_r))) begin
            vec_w[pidx_r] = 1'b0;
            chg_w         = 1'b1;
          end
        end
        if ((op_r == grr_pkg::OP_REACH) && vec_w[d_r]) begin
          out_valid_nxt = 1'b1;
          out_reach_nxt = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end else if (!pend_r && (idx_r == n)) begin
          if (chg_r) begin
            idx_nxt = '0;
            chg_nxt = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
            out_cyc_nxt   = (op_r == grr_pkg::OP_CYCLE) && (|vec_r);
            state_nxt     = S_IDLE;
          end
        end else begin
          vec_nxt = vec_w;
          chg_nxt = chg_w;
          if (idx_r != n) begin
            ctl.rd_en = 1'b1;
            pidx_nxt  = idx_r[NODE_W-1:0];
            pend_nxt  = 1'b1;
            idx_nxt   = idx_r + CNT_W'(1);
          end else begin
            pend_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      chg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      chg_r       <= chg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    s_r         <= s_nxt;
    d_r         <= d_nxt;
    idx_r       <= idx_nxt;
    pidx_r      <= pidx_nxt;
    vec_r       <= vec_nxt;
    out_edge_r  <= out_edge_nxt;
    out_reach_r <= out_reach_nxt;
    out_cyc_r   <= out_cyc_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_edge_added = out_edge_r;
  assign out_reachable  = out_reach_r;
  assign out_has_cycle  = out_cyc_r;
  assign out_status     = out_stat_r;

  a_one_answer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_edge_r, out_reach_r, out_cyc_r, out_stat_r}))
    else $error("more than one answer bit in a result word");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result word while still busy");

  a_add_two: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD) |=> out_valid_r)
    else $error("edge insert did not finish");

  a_clear_now: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (op == grr_pkg::OP_CLEAR)) |=> out_valid_r)
    else $error("clear did not answer");

  a_pend_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_SWEEP))
    else $error("row read pending outside a sweep");

endmodule

@@ hdl/graph_reachability_engine_unit.sv @@
// ----------------------------------------------------------------------------
// graph_reachability_engine_unit
// directed graph store with edge insert, reachability and cycle queries
// ----------------------------------------------------------------------------
// clear, out-of-range and trivial answer from idle; add edge answers from S_ADD
// reach/cycle: repeated passes over the n active nodes, one row read per cycle
//   from the row memory within a pass; reach passes <= n, cycle passes <= n + 1
// one word at a time: the next word is taken at the edge ending the result strobe
// rst_n synchronous: empties the graph at once through per-row valid bits,
//   node_count back to 64, max_out_degree back to 2
module graph_reachability_engine_unit #(
  parameter int MAX_NODES = grr_pkg::MAX_NODES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [grr_pkg::OP_W-1:0]      in_operation,
  input  logic [grr_pkg::NODE_IN_W-1:0] in_src_node,
  input  logic [grr_pkg::NODE_IN_W-1:0] in_dst_node,
  output logic                          out_valid,
  output logic                          out_edge_added,
  output logic                          out_reachable,
  output logic                          out_has_cycle,
  output logic                          out_status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [grr_pkg::APB_AW-1:0]    paddr,
  input  logic [grr_pkg::APB_DW-1:0]    pwdata,
  output logic [grr_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int CW     = (CNT_W > grr_pkg::NCNT_W) ? CNT_W : grr_pkg::NCNT_W;

  logic [grr_pkg::NCNT_W-1:0] node_count_r, node_count_nxt;
  logic [grr_pkg::MDEG_W-1:0] max_deg_r, max_deg_nxt;
  logic                       cfg_wr;
  logic [CNT_W-1:0]           n;

  grr_pkg::mem_ctl_t          ctl;
  logic [NODE_W-1:0]          rd_addr, wr_addr;
  logic [MAX_NODES-1:0]       wr_row, rd_row;
  logic [grr_pkg::DEG_W-1:0]  wr_deg, rd_deg;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    node_count_nxt = node_count_r;
    max_deg_nxt    = max_deg_r;
    if (cfg_wr) begin
      case (paddr[2])
        grr_pkg::REG_NODE_COUNT: node_count_nxt = pwdata[grr_pkg::NCNT_W-1:0];
        default:                 max_deg_nxt    = pwdata[grr_pkg::MDEG_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= grr_pkg::NODE_COUNT_RST;
      max_deg_r    <= grr_pkg::MAX_DEG_RST;
    end else begin
      node_count_r <= node_count_nxt;
      max_deg_r    <= max_deg_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      grr_pkg::REG_NODE_COUNT: prdata = grr_pkg::APB_DW'(node_count_r);
      default:                 prdata = grr_pkg::APB_DW'(max_deg_r);
    endcase
  end

  assign n = (CW'(node_count_r) > CW'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                  : CNT_W'(node_count_r);

  grr_ctrl #(
    .MAX_NODES(MAX_NODES)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .op             (in_operation),
    .src            (in_src_node),
    .dst            (in_dst_node),
    .n              (n),
    .max_deg        (max_deg_r),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_edge_added (out_edge_added),
    .out_reachable  (out_reachable),
    .out_has_cycle  (out_has_cycle),
    .out_status     (out_status),
    .ctl            (ctl),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr),
    .wr_row         (wr_row),
    .wr_deg         (wr_deg),
    .rd_row         (rd_row),
    .rd_deg         (rd_deg)
  );

  grr_store #(
    .MAX_NODES(MAX_NODES)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_row  (wr_row),
    .wr_deg  (wr_deg),
    .rd_row  (rd_row),
    .rd_deg  (rd_deg)
  );

endmodule
